// File: rtl/assert_macros.svh
// Assertion macros shared by the framer RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define VPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define VPF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/vpf_pkg.sv
// Types, codes and constants for the voice packet framer.
// No dependencies; used by every module of the block.
`default_nettype none

package vpf_pkg;

    localparam int MAX_FRAME_LIMIT_DEFAULT = 8192;
    localparam int MAX_RESULTS             = 3;   // most words one input word causes
    localparam int QUEUE_DEPTH             = 4;   // power of two, pointers wrap
    localparam int PTR_W                   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W                   = $clog2(QUEUE_DEPTH + 1);
    localparam int NRES_W                  = $clog2(MAX_RESULTS + 1);

    localparam logic [15:0] SEQ_LIMIT      = 16'h4000;
    localparam logic [7:0]  VARINT_MARK    = 8'h80;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_HEADER  = 2'd1,
        ACT_FRAME   = 2'd2,
        ACT_PAYLOAD = 2'd3
    } vpf_action_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_HEADER_TWICE = 3'd1,
        ST_SEQ_BIG      = 3'd2,
        ST_BAD_LENGTH   = 3'd3,
        ST_NO_HEADER    = 3'd4,
        ST_UNEXPECTED   = 3'd5
    } vpf_status_t;

    typedef struct packed {
        vpf_action_t  action;
        logic [2:0]   frame_type;
        logic [4:0]   target;
        logic [15:0]  sequence_req;
        logic [12:0]  frame_length;
        logic [7:0]   data_byte;
    } vpf_item_t;

    typedef struct packed {
        logic [7:0]   out_byte;
        logic         byte_valid;
        logic         run_last;
        vpf_status_t  status;
        logic         packet_done;
        logic [13:0]  packet_length;
    } vpf_result_t;

    // Results of one accepted word, handed to the queue together in a single push.
    typedef struct packed {
        logic                                valid;
        logic [NRES_W-1:0]                   count;
        vpf_result_t [MAX_RESULTS-1:0]       results;
    } vpf_push_t;

endpackage

`default_nettype wire

// File: rtl/vpf_framer_core.sv
// Packet state and per-word result generation for the voice packet framer.
// Depends on vpf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vpf_framer_core #(
    parameter int MAX_FRAME_LIMIT = vpf_pkg::MAX_FRAME_LIMIT_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire vpf_pkg::vpf_item_t  item,
    output vpf_pkg::vpf_push_t       push
);

    localparam int NRES_W = vpf_pkg::NRES_W;

    logic        header_written_reg, header_written_next;
    logic        frame_started_reg,  frame_started_next;
    logic [12:0] payload_left_reg,   payload_left_next;
    logic [13:0] bytes_emitted_reg,  bytes_emitted_next;

    logic [13:0] len1, len2, len3;
    logic        bad_length;

    function automatic vpf_pkg::vpf_result_t make_result(
        input logic [7:0]           b,
        input logic                 valid,
        input logic                 last,
        input vpf_pkg::vpf_status_t st,
        input logic                 done,
        input logic [13:0]          len
    );
        vpf_pkg::vpf_result_t r;
        r.out_byte      = b;
        r.byte_valid    = valid;
        r.run_last      = last;
        r.status        = st;
        r.packet_done   = done;
        r.packet_length = len;
        return r;
    endfunction

    assign len1 = bytes_emitted_reg + 14'd1;
    assign len2 = bytes_emitted_reg + 14'd2;
    assign len3 = bytes_emitted_reg + 14'd3;
    assign bad_length = (item.frame_length == 13'd0) ||
                        (32'(item.frame_length) >= MAX_FRAME_LIMIT);

    always_comb begin
        header_written_next = header_written_reg;
        frame_started_next  = frame_started_reg;
        payload_left_next   = payload_left_reg;
        bytes_emitted_next  = bytes_emitted_reg;
        push.valid   = accept;
        push.count   = NRES_W'(1);
        push.results = '0;
        case (item.action)
            vpf_pkg::ACT_START: begin
                push.results[0] = make_result(8'd0, 1'b0, 1'b1, vpf_pkg::ST_OK, 1'b0, 14'd0);
                header_written_next = 1'b0;
                frame_started_next  = 1'b0;
                payload_left_next   = 13'd0;
                bytes_emitted_next  = 14'd0;
            end
            vpf_pkg::ACT_HEADER: begin
                if (header_written_reg) begin
                    push.results[0] = make_result(8'd0, 1'b0, 1'b1,
                        vpf_pkg::ST_HEADER_TWICE, 1'b0, bytes_emitted_reg);
                end else if (item.sequence_req >= vpf_pkg::SEQ_LIMIT) begin
                    push.results[0] = make_result(8'd0, 1'b0, 1'b1,
                        vpf_pkg::ST_SEQ_BIG, 1'b0, bytes_emitted_reg);
                end else begin
                    push.results[0] = make_result({item.frame_type, item.target}, 1'b1,
                        1'b0, vpf_pkg::ST_OK, 1'b0, len1);
                    header_written_next = 1'b1;
                    if (item.sequence_req < 16'(vpf_pkg::VARINT_MARK)) begin
                        push.count = NRES_W'(2);
                        push.results[1] = make_result(item.sequence_req[7:0], 1'b1, 1'b1,
                            vpf_pkg::ST_OK, 1'b0, len2);
                        bytes_emitted_next = len2;
                    end else begin
                        push.count = NRES_W'(3);
                        push.results[1] = make_result(
                            item.sequence_req[15:8] | vpf_pkg::VARINT_MARK, 1'b1, 1'b0,
                            vpf_pkg::ST_OK, 1'b0, len2);
                        push.results[2] = make_result(item.sequence_req[7:0], 1'b1, 1'b1,
                            vpf_pkg::ST_OK, 1'b0, len3);
                        bytes_emitted_next = len3;
                    end
                end
            end
            vpf_pkg::ACT_FRAME: begin
                if (bad_length) begin
                    push.results[0] = make_result(8'd0, 1'b0, 1'b1,
                        vpf_pkg::ST_BAD_LENGTH, 1'b0, bytes_emitted_reg);
                end else if (!header_written_reg) begin
                    push.results[0] = make_result(8'd0, 1'b0, 1'b1,
                        vpf_pkg::ST_NO_HEADER, 1'b0, bytes_emitted_reg);
                end else if (frame_started_reg) begin
                    push.results[0] = make_result(8'd0, 1'b0, 1'b1,
                        vpf_pkg::ST_UNEXPECTED, 1'b0, bytes_emitted_reg);
                end else begin
                    frame_started_next = 1'b1;
                    payload_left_next  = item.frame_length;
                    if (item.frame_length < 13'(vpf_pkg::VARINT_MARK)) begin
                        push.results[0] = make_result(item.frame_length[7:0], 1'b1, 1'b1,
                            vpf_pkg::ST_OK, 1'b0, len1);
                        bytes_emitted_next = len1;
                    end else begin
                        push.count = NRES_W'(2);
                        push.results[0] = make_result(
                            {3'd0, item.frame_length[12:8]} | vpf_pkg::VARINT_MARK, 1'b1,
                            1'b0, vpf_pkg::ST_OK, 1'b0, len1);
                        push.results[1] = make_result(item.frame_length[7:0], 1'b1, 1'b1,
                            vpf_pkg::ST_OK, 1'b0, len2);
                        bytes_emitted_next = len2;
                    end
                end
            end
            vpf_pkg::ACT_PAYLOAD: begin
                if (payload_left_reg == 13'd0) begin
                    push.results[0] = make_result(8'd0, 1'b0, 1'b1,
                        vpf_pkg::ST_UNEXPECTED, 1'b0, bytes_emitted_reg);
                end else begin
                    push.results[0] = make_result(item.data_byte, 1'b1, 1'b1,
                        vpf_pkg::ST_OK, payload_left_reg == 13'd1, len1);
                    payload_left_next  = payload_left_reg - 13'd1;
                    bytes_emitted_next = len1;
                end
            end
            default: begin
                push.results[0] = make_result(8'd0, 1'b0, 1'b1,
                    vpf_pkg::ST_UNEXPECTED, 1'b0, bytes_emitted_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_written_reg <= 1'b0;
            frame_started_reg  <= 1'b0;
            payload_left_reg   <= 13'd0;
            bytes_emitted_reg  <= 14'd0;
        end else if (accept) begin
            header_written_reg <= header_written_next;
            frame_started_reg  <= frame_started_next;
            payload_left_reg   <= payload_left_next;
            bytes_emitted_reg  <= bytes_emitted_next;
        end
    end

    `VPF_ASSERT(a_payload_needs_frame,
        (payload_left_reg != 13'd0) |-> frame_started_reg,
        "payload count set without a frame")
    `VPF_ASSERT(a_frame_needs_header,
        frame_started_reg |-> header_written_reg,
        "frame started without a header")
    `VPF_ASSERT(a_start_clears,
        (accept && item.action == vpf_pkg::ACT_START) |=>
            (bytes_emitted_reg == 14'd0 && !header_written_reg),
        "start word did not clear the packet")

endmodule

`default_nettype wire

// File: rtl/vpf_result_queue.sv
// Small result queue: takes up to three words per cycle, hands out one per cycle while out_ready is high.
// Depends on vpf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vpf_result_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire vpf_pkg::vpf_push_t   push,
    output logic                      space_ok,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output vpf_pkg::vpf_result_t      out_result
);

    localparam int DEPTH = vpf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = vpf_pkg::PTR_W;
    localparam int CNT_W = vpf_pkg::CNT_W;

    vpf_pkg::vpf_result_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    logic [CNT_W-1:0] push_n;

    assign pop       = out_valid && out_ready;
    assign push_n    = push.valid ? CNT_W'(push.count) : CNT_W'(0);
    assign out_valid = (count_reg != CNT_W'(0));
    assign out_result = entries[rd_ptr_reg];
    // room for a full header burst
    assign space_ok  = (count_reg <= CNT_W'(DEPTH - vpf_pkg::MAX_RESULTS));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + push_n - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < vpf_pkg::MAX_RESULTS; k++) begin
            if (push.valid && (CNT_W'(k) < push_n)) begin
                entries[PTR_W'(wr_ptr_reg + PTR_W'(k))] <= push.results[k];
            end
        end
    end

    `VPF_ASSERT(a_no_overflow,
        push.valid |-> (count_reg + push_n - CNT_W'(pop) <= CNT_W'(DEPTH)),
        "result queue overflow")
    `VPF_ASSERT(a_burst_ends_last,
        (push.valid && push.count != '0) |-> push.results[push.count - 1'b1].run_last,
        "burst of results does not end with last flag")

endmodule

`default_nettype wire

// File: rtl/voice_packet_framer.sv
// Top level of the voice packet framer: input unpacking, core and result queue.
// Depends on vpf_pkg, vpf_framer_core and vpf_result_queue.
`default_nettype none

// Builds a voice packet one output word at a time. Each input word carries an action in
// s_tuser: start clears the packet, header sends a type/target byte and the sequence as a
// one- or two-byte prefix varint, frame sends the payload length as a varint, payload
// passes one byte through until the length is used up. Every input word causes one to three
// output words, the last one flagged by m_tlast; a rejected word gives a single word with
// m_tuser low and the error in the status field, and leaves the packet untouched. Rate:
// an input word is accepted every cycle while each causes one output word and m_tready is
// high; a header gives up to three words, handed out by the result queue one per cycle. The
// input side takes a word whenever the queue holds at most one waiting result, so a stalled
// output does not block the next input word at once. Results are registered in the queue.
module voice_packet_framer #(
    parameter int MAX_FRAME_LIMIT = vpf_pkg::MAX_FRAME_LIMIT_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // frame_type[2:0], target[7:3], sequence_req[23:8], frame_length[36:24],
    // data_byte[44:37], zero pad[47:45]
    input  wire logic [47:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_byte[7:0], status[10:8], packet_done[11], packet_length[25:12], zero pad[31:26]
    output logic [31:0]      m_tdata,
    // byte_valid[0]
    output logic [0:0]       m_tuser,
    output logic             m_tlast
);

    vpf_pkg::vpf_item_t   item;
    vpf_pkg::vpf_push_t   push;
    vpf_pkg::vpf_result_t out_result;
    logic                 accept;

    // unpack the input word
    assign item.action       = vpf_pkg::vpf_action_t'(s_tuser);
    assign item.frame_type   = s_tdata[2:0];
    assign item.target       = s_tdata[7:3];
    assign item.sequence_req = s_tdata[23:8];
    assign item.frame_length = s_tdata[36:24];
    assign item.data_byte    = s_tdata[44:37];

    assign accept = s_tvalid && s_tready;

    vpf_framer_core #(
        .MAX_FRAME_LIMIT (MAX_FRAME_LIMIT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (item),
        .push    (push)
    );

    vpf_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .space_ok   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // pack the output word
    assign m_tdata = {6'd0, out_result.packet_length, out_result.packet_done,
                      out_result.status, out_result.out_byte};
    assign m_tuser = out_result.byte_valid;
    assign m_tlast = out_result.run_last;

endmodule

`default_nettype wire
